FILE: rtl/smf_pkg.sv
// ----------------------------------------------------------------------------
// smf_pkg
// Shared constants and types for the sliding median filter and its cells.
// ----------------------------------------------------------------------------
package smf_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int HALF_W       = 3;
    localparam int MAX_HALF_DEF = 7;
    localparam int HALF_RESET   = 2;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_CLEAR
    } t_cell_op;

    // command broadcast to every cell of the sorted chain
    typedef struct packed {
        t_cell_op                    op;
        logic signed [SAMPLE_W-1:0]  din;
    } t_cell_cmd;

endpackage

FILE: rtl/smf_cell.sv
// ----------------------------------------------------------------------------
// smf_cell
// One slot of the sorted window: holds a sample and its age, drops the
// oldest sample and inserts the new one in order together with its neighbors.
// ----------------------------------------------------------------------------
module smf_cell
    import smf_pkg::*;
#(
    parameter int DEPTH = 2 * MAX_HALF_DEF + 1,
    parameter int AGE_W = $clog2(DEPTH),
    parameter int IDX   = 0
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cell_cmd                  i_cmd,
    input  logic signed [SAMPLE_W-1:0] i_right_val,
    input  logic [AGE_W-1:0]           i_right_age,
    input  logic signed [SAMPLE_W-1:0] i_left_cval,
    input  logic [AGE_W-1:0]           i_left_cage,
    input  logic                       i_left_gt,
    input  logic                       i_left_del,
    output logic signed [SAMPLE_W-1:0] o_val,
    output logic [AGE_W-1:0]           o_age,
    output logic signed [SAMPLE_W-1:0] o_cval,
    output logic [AGE_W-1:0]           o_cage,
    output logic                       o_gt,
    output logic                       o_del
);

    localparam logic [AGE_W-1:0] AGE_OLD  = AGE_W'(DEPTH - 1);
    localparam logic [AGE_W-1:0] AGE_INIT = AGE_W'(IDX);
    localparam bit               IS_END   = (IDX == DEPTH - 1);

    logic signed [SAMPLE_W-1:0] r_val, n_val;
    logic [AGE_W-1:0]           r_age, n_age;
    logic signed [SAMPLE_W-1:0] w_din;
    logic                       w_old;

    assign w_din  = i_cmd.din;
    assign w_old  = (r_age == AGE_OLD);
    // oldest sample sits at or left of this slot
    assign o_del  = i_left_del | w_old;
    // compacted list entry once the oldest sample is taken out
    assign o_cval = o_del ? i_right_val : r_val;
    assign o_cage = o_del ? i_right_age : r_age;
    assign o_gt   = IS_END ? 1'b1 : (o_cval > w_din);
    assign o_val  = r_val;
    assign o_age  = r_age;

    always_comb begin
        n_val = r_val;
        n_age = r_age;
        unique case (i_cmd.op)
            CELL_PUSH: begin
                if (i_left_gt) begin
                    n_val = i_left_cval;
                    n_age = i_left_cage + AGE_W'(1);
                end else if (o_gt) begin
                    n_val = w_din;
                    n_age = '0;
                end else begin
                    n_val = o_cval;
                    n_age = o_cage + AGE_W'(1);
                end
            end
            CELL_CLEAR: begin
                n_val = '0;
                n_age = AGE_INIT;
            end
            default: begin
                n_val = r_val;
                n_age = r_age;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= '0;
            r_age <= AGE_INIT;
        end else begin
            r_val <= n_val;
            r_age <= n_age;
        end
    end

endmodule

FILE: rtl/smf_median.sv
// ----------------------------------------------------------------------------
// smf_median
// Picks the median from the sorted chain: the window entry with exactly
// half_width younger-window entries below it in sort order.
// ----------------------------------------------------------------------------
module smf_median
    import smf_pkg::*;
#(
    parameter int DEPTH = 2 * MAX_HALF_DEF + 1,
    parameter int AGE_W = $clog2(DEPTH)
) (
    input  logic [DEPTH-1:0][SAMPLE_W-1:0] i_vals,
    input  logic [DEPTH-1:0][AGE_W-1:0]    i_ages,
    input  logic [HALF_W-1:0]              i_half,
    output logic [SAMPLE_W-1:0]            o_median
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [HALF_W:0]    w_span;
    logic [DEPTH-1:0]   w_elig;
    logic [DEPTH-1:0]   w_hit;
    logic [DEPTH-1:0]   w_below;
    logic [CNT_W-1:0]   w_cnt;

    assign w_span = {i_half, 1'b1};

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_elig[i] = (32'(i_ages[i]) < 32'(w_span));
        end
    end

    always_comb begin
        w_hit   = '0;
        w_below = '0;
        w_cnt   = '0;
        for (int i = 0; i < DEPTH; i++) begin
            for (int j = 0; j < DEPTH; j++) begin
                w_below[j] = w_elig[j] && (j < i);
            end
            w_cnt    = CNT_W'($countones(w_below));
            w_hit[i] = w_elig[i] && (32'(w_cnt) == 32'(i_half));
        end
    end

    always_comb begin
        o_median = '0;
        for (int i = 0; i < DEPTH; i++) begin
            o_median = o_median | (w_hit[i] ? i_vals[i] : '0);
        end
    end

endmodule

FILE: rtl/sliding_median_filter.sv
// ----------------------------------------------------------------------------
// sliding_median_filter
// Zero-padded 1-D median filter over rows of signed 16-bit samples.
// ----------------------------------------------------------------------------
// Usage: samples enter on i_in_valid / o_in_stall with i_row_last on the final
// sample of a row; medians leave on o_out_valid / i_out_stall, o_last marking
// a row's final median. The window of 2*half_width+1 samples lives in a chain
// of sorted cells; each sample drops the oldest entry and is inserted in order,
// and a select stage reads the median off the chain.
// Throughput: one sample per cycle inside a row, unless o_in_stall holds the
// input. Each median is read off the chain once the sample that completes its
// window is in, and is registered in the output register. A row end shifts in
// up to half_width padding zeros, then the chain is cleared for the next row.
// The output register frees the input side: a new sample is taken while a
// median waits, as long as the pending median has a place to go. With the
// receiver stalled, one median waits in the output register, one waits in the
// chain, and o_in_stall rises.
// half_width, written on i_cfg_we, saturates to MAX_HALF; the user must write
// it only while idle, not enforced by the block. Reset (synchronous, active
// low) clears the chain to zeros, empties the output, sets half_width to 2.
// ----------------------------------------------------------------------------
module sliding_median_filter
    import smf_pkg::*;
#(
    parameter int MAX_HALF = MAX_HALF_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [HALF_W-1:0]          i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_row_last,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [SAMPLE_W-1:0] o_filtered,
    output logic                       o_last
);

    localparam int DEPTH = 2 * MAX_HALF + 1;
    localparam int AGE_W = $clog2(DEPTH);
    localparam int HALF_INIT = (HALF_RESET < MAX_HALF) ? HALF_RESET : MAX_HALF;

    logic [HALF_W-1:0] r_half;
    logic [HALF_W-1:0] r_row_fill, n_row_fill;
    logic [HALF_W-1:0] r_flush, n_flush;
    logic              r_pmed, n_pmed;
    logic              r_plast, n_plast;
    logic              r_ovalid, n_ovalid;
    logic signed [SAMPLE_W-1:0] r_filtered;
    logic              r_olast;

    logic              w_load_ok, w_load, w_clear, w_flush_go, w_in_acc;
    logic              w_emit;
    logic [HALF_W-1:0] w_fill_inc, w_pending;
    t_cell_cmd         w_cmd;
    logic [SAMPLE_W-1:0] w_median;

    logic [DEPTH:0][SAMPLE_W-1:0] w_val;
    logic [DEPTH:0][AGE_W-1:0]    w_age;
    logic [DEPTH:0][SAMPLE_W-1:0] w_cval;
    logic [DEPTH:0][AGE_W-1:0]    w_cage;
    logic [DEPTH:0]               w_gt;
    logic [DEPTH:0]               w_del;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= HALF_W'(HALF_INIT);
        end else if (i_cfg_we) begin
            if (32'(i_cfg_data) > 32'(MAX_HALF)) begin
                r_half <= HALF_W'(MAX_HALF);
            end else begin
                r_half <= i_cfg_data;
            end
        end
    end

    // ---------------- control ----------------
    assign w_load_ok  = !r_ovalid || !i_out_stall;
    assign w_load     = r_pmed && w_load_ok;
    assign w_clear    = w_load && r_plast;
    assign w_flush_go = (r_flush != '0) && (!r_pmed || w_load_ok);
    assign o_in_stall = (r_flush != '0) || (r_pmed && (r_plast || !w_load_ok));
    assign w_in_acc   = i_in_valid && !o_in_stall;

    assign w_emit     = (r_row_fill >= r_half);
    assign w_fill_inc = w_emit ? r_row_fill : (r_row_fill + HALF_W'(1));
    assign w_pending  = (w_fill_inc < r_half) ? w_fill_inc : r_half;

    always_comb begin
        w_cmd.op  = CELL_HOLD;
        w_cmd.din = '0;
        priority if (w_clear) begin
            w_cmd.op = CELL_CLEAR;
        end else if (w_in_acc) begin
            w_cmd.op  = CELL_PUSH;
            w_cmd.din = i_sample;
        end else if (w_flush_go) begin
            // padding zero past the row end
            w_cmd.op = CELL_PUSH;
        end
    end

    always_comb begin
        n_row_fill = r_row_fill;
        n_flush    = r_flush;
        n_pmed     = r_pmed;
        n_plast    = r_plast;
        n_ovalid   = r_ovalid;

        if (w_load) begin
            n_ovalid = 1'b1;
            n_pmed   = 1'b0;
        end else if (!i_out_stall) begin
            n_ovalid = 1'b0;
        end

        if (w_in_acc) begin
            n_pmed  = w_emit;
            n_plast = i_row_last && (w_pending == '0);
            if (i_row_last) begin
                n_flush = w_pending;
            end else begin
                n_row_fill = w_fill_inc;
            end
        end else if (w_flush_go) begin
            n_flush = r_flush - HALF_W'(1);
            n_pmed  = 1'b1;
            n_plast = (r_flush == HALF_W'(1));
        end

        if (w_clear) begin
            n_row_fill = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_fill <= '0;
            r_flush    <= '0;
            r_pmed     <= 1'b0;
            r_plast    <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_row_fill <= n_row_fill;
            r_flush    <= n_flush;
            r_pmed     <= n_pmed;
            r_plast    <= n_plast;
            r_ovalid   <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_filtered <= w_median;
            r_olast    <= r_plast;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_filtered  = r_filtered;
    assign o_last      = r_olast;

    // ---------------- sorted cell chain ----------------
    assign w_val[DEPTH]  = '0;
    assign w_age[DEPTH]  = '0;
    assign w_cval[0]     = '0;
    assign w_cage[0]     = '0;
    assign w_gt[0]       = 1'b0;
    assign w_del[0]      = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        smf_cell #(
            .DEPTH (DEPTH),
            .AGE_W (AGE_W),
            .IDX   (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (w_cmd),
            .i_right_val (w_val[g+1]),
            .i_right_age (w_age[g+1]),
            .i_left_cval (w_cval[g]),
            .i_left_cage (w_cage[g]),
            .i_left_gt   (w_gt[g]),
            .i_left_del  (w_del[g]),
            .o_val       (w_val[g]),
            .o_age       (w_age[g]),
            .o_cval      (w_cval[g+1]),
            .o_cage      (w_cage[g+1]),
            .o_gt        (w_gt[g+1]),
            .o_del       (w_del[g+1])
        );
    end

    smf_median #(
        .DEPTH (DEPTH),
        .AGE_W (AGE_W)
    ) u_median (
        .i_vals   (w_val[DEPTH-1:0]),
        .i_ages   (w_age[DEPTH-1:0]),
        .i_half   (r_half),
        .o_median (w_median)
    );

`ifndef NO_ASSERTIONS
    // the chain always holds exactly one entry due to leave
    a_oldest_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_del[DEPTH])
        else $error("no oldest entry found in the sorted chain");

    // chain is empty right after the last median of a row leaves it
    a_clear_after_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_plast) |=> (w_val[DEPTH-1:0] == '0))
        else $error("chain not cleared after row end");

    // padding shifts never run while a row's final median is still pending
    a_flush_vs_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_flush != '0) |-> !(r_pmed && r_plast))
        else $error("flush pending together with final median");
`endif

endmodule
